// File: rtl/bundle_branch_predecoder_assert.svh
// Assertion macros for the branch predecoder RTL, used by the merge stage.
// No dependencies; taken in by `include where checks are written.
`ifndef BUNDLE_BRANCH_PREDECODER_ASSERT_SVH
`define BUNDLE_BRANCH_PREDECODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BBP_ASSERT_NOW(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bbp assertion failed");

// next-cycle implication, disabled during reset
`define BBP_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bbp assertion failed");

`endif

// File: rtl/bbp_pkg.sv
// Types, field positions and decode codes for the bundle branch predecoder.
// No dependencies; used by every module of the block.
`default_nettype none

package bbp_pkg;

    localparam int unsigned NUM_SLOTS  = 3;
    localparam int unsigned TMPL_W     = 5;
    localparam int unsigned SLOT_W     = 41;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned OFF_W      = 25;
    localparam int unsigned HALF_W     = 64;
    localparam int unsigned S_TDATA_W  = 2 * HALF_W;
    localparam int unsigned RES_BITS   = NUM_SLOTS * (KIND_W + OFF_W);
    localparam int unsigned M_TDATA_W  = ((RES_BITS + 7) / 8) * 8;
    localparam int unsigned OFF_BASE   = NUM_SLOTS * KIND_W;

    typedef logic [TMPL_W-1:0] tmpl_t;
    typedef logic [SLOT_W-1:0] slot_word_t;
    typedef logic [1:0]        slot_idx_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_OTHER  = 2'd0,
        KIND_CALL   = 2'd1,
        KIND_BRANCH = 2'd2,
        KIND_RETURN = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [OFF_W-1:0]   offset;
    } slot_res_t;

    // major opcodes of the branch unit
    localparam logic [3:0] OP_INDIRECT = 4'h0;
    localparam logic [3:0] OP_CALL_IND = 4'h1;
    localparam logic [3:0] OP_BR_REL   = 4'h4;
    localparam logic [3:0] OP_CALL_REL = 4'h5;

    localparam logic [5:0] X6_RETURN   = 6'h21;
    localparam logic [5:0] X6_BR_IND   = 6'h20;

    localparam logic [2:0] BTYPE_RET   = 3'd4;
    localparam logic [2:0] BTYPE_COND  = 3'd0;
    localparam logic [2:0] BTYPE_IA    = 3'd1;

    localparam tmpl_t TMPL_BBB   = 5'h16;
    localparam tmpl_t TMPL_BBB_S = 5'h17;
    localparam tmpl_t TMPL_MBB   = 5'h12;
    localparam tmpl_t TMPL_MBB_S = 5'h13;
    localparam tmpl_t TMPL_MIB   = 5'h10;
    localparam tmpl_t TMPL_MIB_S = 5'h11;
    localparam tmpl_t TMPL_MMB   = 5'h18;
    localparam tmpl_t TMPL_MMB_S = 5'h19;
    localparam tmpl_t TMPL_MFB   = 5'h1C;
    localparam tmpl_t TMPL_MFB_S = 5'h1D;

    localparam slot_idx_t SLOT_FIRST = 2'd0;
    localparam slot_idx_t SLOT_MID   = 2'd1;
    localparam slot_idx_t SLOT_LAST  = 2'd2;

    function automatic logic is_branch_unit(input tmpl_t tmpl, input slot_idx_t slot);
        logic bu;
        bu = 1'b0;
        case (tmpl) inside
            TMPL_BBB, TMPL_BBB_S: begin
                bu = 1'b1;
            end
            TMPL_MBB, TMPL_MBB_S: begin
                bu = (slot != SLOT_FIRST);
            end
            TMPL_MIB, TMPL_MIB_S, TMPL_MMB, TMPL_MMB_S, TMPL_MFB, TMPL_MFB_S: begin
                bu = (slot == SLOT_LAST);
            end
            default: begin
                bu = 1'b0;
            end
        endcase
        return bu;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bbp_slot_lane.sv
// One decode lane: classifies a single 41-bit slot and forms its displacement.
// Depends on bbp_pkg.
`default_nettype none

module bbp_slot_lane (
    input  wire bbp_pkg::slot_word_t slot_word,
    input  wire logic                bunit,
    output bbp_pkg::slot_res_t       res
);

    logic [3:0]                 opcode;
    logic [5:0]                 x6;
    logic [2:0]                 btype;
    logic [bbp_pkg::OFF_W-1:0]  disp;

    assign opcode = slot_word[40:37];
    assign x6     = slot_word[32:27];
    assign btype  = slot_word[8:6];
    // sign from bit 36, imm20b from bits 13..32, scaled by 16
    assign disp   = {slot_word[36], slot_word[32:13], 4'b0000};

    always_comb begin
        res.kind   = bbp_pkg::KIND_OTHER;
        res.offset = '0;
        if (bunit) begin
            case (opcode)
                bbp_pkg::OP_CALL_REL: begin
                    res.kind   = bbp_pkg::KIND_CALL;
                    res.offset = disp;
                end
                bbp_pkg::OP_BR_REL: begin
                    res.kind   = bbp_pkg::KIND_BRANCH;
                    res.offset = disp;
                end
                bbp_pkg::OP_CALL_IND: begin
                    res.kind = bbp_pkg::KIND_CALL;
                end
                bbp_pkg::OP_INDIRECT: begin
                    if (x6 == bbp_pkg::X6_RETURN && btype == bbp_pkg::BTYPE_RET) begin
                        res.kind = bbp_pkg::KIND_RETURN;
                    end else if (x6 == bbp_pkg::X6_BR_IND &&
                                 (btype == bbp_pkg::BTYPE_COND ||
                                  btype == bbp_pkg::BTYPE_IA)) begin
                        res.kind = bbp_pkg::KIND_BRANCH;
                    end
                end
                default: begin
                    res.kind = bbp_pkg::KIND_OTHER;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/bbp_merge.sv
// Merge stage: registers the three lane results and packs them into one beat.
// Depends on bbp_pkg and bundle_branch_predecoder_assert.svh.
`default_nettype none

`include "bundle_branch_predecoder_assert.svh"

module bbp_merge (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire bbp_pkg::slot_res_t            lane_res [bbp_pkg::NUM_SLOTS],
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [bbp_pkg::M_TDATA_W-1:0]      m_tdata
);

    logic               valid_reg;
    logic               valid_next;
    bbp_pkg::slot_res_t res_reg  [bbp_pkg::NUM_SLOTS];
    logic               load;

    assign in_ready   = !valid_reg || m_tready;
    assign load       = in_valid && in_ready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < bbp_pkg::NUM_SLOTS; i++) begin
                res_reg[i] <= lane_res[i];
            end
        end
    end

    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < bbp_pkg::NUM_SLOTS; i++) begin
            m_tdata[i*bbp_pkg::KIND_W +: bbp_pkg::KIND_W] = res_reg[i].kind;
            m_tdata[bbp_pkg::OFF_BASE + i*bbp_pkg::OFF_W +: bbp_pkg::OFF_W] =
                res_reg[i].offset;
        end
    end

    assign m_tvalid = valid_reg;

    `BBP_ASSERT_NOW(a_backpressure, aclk, aresetn, valid_reg && !m_tready, !in_ready)
    `BBP_ASSERT_NEXT(a_load_shows, aclk, aresetn, load, valid_reg)
    `BBP_ASSERT_NOW(a_off0_kind, aclk, aresetn, valid_reg && res_reg[0].offset != '0, res_reg[0].kind == bbp_pkg::KIND_CALL || res_reg[0].kind == bbp_pkg::KIND_BRANCH)
    `BBP_ASSERT_NOW(a_off1_kind, aclk, aresetn, valid_reg && res_reg[1].offset != '0, res_reg[1].kind == bbp_pkg::KIND_CALL || res_reg[1].kind == bbp_pkg::KIND_BRANCH)
    `BBP_ASSERT_NOW(a_off2_kind, aclk, aresetn, valid_reg && res_reg[2].offset != '0, res_reg[2].kind == bbp_pkg::KIND_CALL || res_reg[2].kind == bbp_pkg::KIND_BRANCH)

endmodule

`default_nettype wire

// File: rtl/bundle_branch_predecoder.sv
// Top level of the bundle branch predecoder: three slot lanes and a merge stage.
// Depends on bbp_pkg, bbp_slot_lane and bbp_merge.
//
//   channel | dir | tdata                                  | beat
//   s_      | in  | 128 b: bundle_low, bundle_high         | one bundle
//   m_      | out | 88 b: 3 kinds, 3 offsets, zero pad     | one result
//
// One bundle per cycle unless a held m_ beat stalls; the result appears in the cycle after
// the input beat, from the single output register in the merge stage.
// Synchronous active-low reset clears only the output valid.
// A stalled m_ beat holds; s_tready drops only while it is held.
`default_nettype none

module bundle_branch_predecoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [63:0] bundle_low, [127:64] bundle_high
    input  wire logic [bbp_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] slot0_kind, [3:2] slot1_kind, [5:4] slot2_kind,
    // [30:6] slot0_offset, [55:31] slot1_offset, [80:56] slot2_offset, [87:81] zero
    output logic [bbp_pkg::M_TDATA_W-1:0]      m_tdata
);

    bbp_pkg::tmpl_t     tmpl;
    bbp_pkg::slot_res_t lane_res [bbp_pkg::NUM_SLOTS];

    assign tmpl = s_tdata[bbp_pkg::TMPL_W-1:0];

    for (genvar g = 0; g < bbp_pkg::NUM_SLOTS; g++) begin : g_lane
        logic bunit;
        assign bunit = bbp_pkg::is_branch_unit(tmpl, bbp_pkg::slot_idx_t'(g));
        bbp_slot_lane u_lane (
            .slot_word (s_tdata[bbp_pkg::TMPL_W + g*bbp_pkg::SLOT_W +: bbp_pkg::SLOT_W]),
            .bunit     (bunit),
            .res       (lane_res[g])
        );
    end

    bbp_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .lane_res (lane_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// File: tb/bundle_branch_predecoder_monitor.sv
`timescale 1ns / 1ps
// Result checker for the bundle branch predecoder: watches both stream channels,
// predicts each result beat from the accepted bundle and compares it field by field.
// Depends on bbp_pkg only.

module bundle_branch_predecoder_monitor
    import bbp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    // [63:0] bundle_low, [127:64] bundle_high
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    // [1:0] slot0_kind, [3:2] slot1_kind, [5:4] slot2_kind,
    // [30:6] slot0_offset, [55:31] slot1_offset, [80:56] slot2_offset, [87:81] zero
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    output int unsigned               mismatches,
    output int unsigned               pending
);

    localparam int unsigned MAX_REPORTS = 10;

    typedef slot_res_t [NUM_SLOTS-1:0] bundle_decode_t;

    bundle_decode_t predicted_decodes[$];
    int unsigned    results_seen;

    function automatic logic in_branch_unit(input tmpl_t tmpl, input slot_idx_t idx);
        case (tmpl)
            TMPL_BBB, TMPL_BBB_S: begin
                return 1'b1;
            end
            TMPL_MBB, TMPL_MBB_S: begin
                return idx != SLOT_FIRST;
            end
            TMPL_MIB, TMPL_MIB_S, TMPL_MMB, TMPL_MMB_S, TMPL_MFB, TMPL_MFB_S: begin
                return idx == SLOT_LAST;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic slot_res_t decode_slot(input slot_word_t word, input logic bunit);
        slot_res_t  res;
        logic [3:0] opcode;
        logic [5:0] x6;
        logic [2:0] btype;
        res.kind   = KIND_OTHER;
        res.offset = '0;
        opcode     = word[40:37];
        x6         = word[32:27];
        btype      = word[8:6];
        if (bunit) begin
            case (opcode)
                OP_CALL_REL: begin
                    res.kind   = KIND_CALL;
                    res.offset = {word[36], word[32:13], 4'b0000};
                end
                OP_BR_REL: begin
                    res.kind   = KIND_BRANCH;
                    res.offset = {word[36], word[32:13], 4'b0000};
                end
                OP_CALL_IND: begin
                    res.kind = KIND_CALL;
                end
                OP_INDIRECT: begin
                    if (x6 == X6_RETURN && btype == BTYPE_RET) begin
                        res.kind = KIND_RETURN;
                    end else if (x6 == X6_BR_IND && (btype == BTYPE_COND || btype == BTYPE_IA)) begin
                        res.kind = KIND_BRANCH;
                    end
                end
                default: begin
                end
            endcase
        end
        return res;
    endfunction

    function automatic bundle_decode_t predict_decode(input logic [S_TDATA_W-1:0] bundle);
        bundle_decode_t dec;
        tmpl_t          tmpl;
        tmpl = bundle[TMPL_W-1:0];
        for (int s = 0; s < NUM_SLOTS; s++) begin
            dec[s] = decode_slot(bundle[TMPL_W + SLOT_W*s +: SLOT_W],
                                 in_branch_unit(tmpl, slot_idx_t'(s)));
        end
        return dec;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at result %0d, %s: expected 0x%0h, got 0x%0h",
                     results_seen, field, exp_v, act_v);
        end
    endtask

    initial begin
        mismatches   = 0;
        pending      = 0;
        results_seen = 0;
    end

    always @(posedge aclk) begin
        bundle_decode_t   exp_dec;
        kind_t            act_kind;
        logic [OFF_W-1:0] act_off;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predicted_decodes.push_back(predict_decode(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (predicted_decodes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result beat 0x%0h", m_tdata);
                    end
                end else begin
                    exp_dec = predicted_decodes.pop_front();
                    for (int s = 0; s < NUM_SLOTS; s++) begin
                        act_kind = kind_t'(m_tdata[KIND_W*s +: KIND_W]);
                        act_off  = m_tdata[OFF_BASE + OFF_W*s +: OFF_W];
                        if (act_kind !== exp_dec[s].kind) begin
                            report_mismatch($sformatf("slot%0d_kind", s),
                                            32'(exp_dec[s].kind), 32'(act_kind));
                        end
                        if (act_off !== exp_dec[s].offset) begin
                            report_mismatch($sformatf("slot%0d_offset", s),
                                            32'(exp_dec[s].offset), 32'(act_off));
                        end
                    end
                    if (m_tdata[M_TDATA_W-1:RES_BITS] !== '0) begin
                        report_mismatch("padding", 32'd0, 32'(m_tdata[M_TDATA_W-1:RES_BITS]));
                    end
                end
                results_seen++;
            end
            pending <= predicted_decodes.size();
        end
    end

endmodule

// File: tb/bundle_branch_predecoder_test.sv
`timescale 1ns / 1ps
// Top of the bundle branch predecoder testbench: clock, reset, bundle stimulus,
// result back-pressure, watchdog and verdict. Depends on bbp_pkg, the block and
// bundle_branch_predecoder_monitor.

module bundle_branch_predecoder_test;
    import bbp_pkg::*;

    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned RANDOM_BUNDLES = 1850;
    localparam int unsigned IDLE_LIMIT     = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;

    localparam tmpl_t      TMPL_MLX   = 5'h04;
    localparam tmpl_t      TMPL_MLX_S = 5'h05;
    localparam logic [5:0] X6_NOP     = 6'h00;

    localparam tmpl_t BRANCH_TMPLS [10] = '{
        TMPL_BBB, TMPL_BBB_S, TMPL_MBB, TMPL_MBB_S, TMPL_MIB,
        TMPL_MIB_S, TMPL_MMB, TMPL_MMB_S, TMPL_MFB, TMPL_MFB_S
    };

    // major opcodes that never decode to a branch class
    localparam logic [3:0] SPARE_OPS [12] = '{
        4'h2, 4'h3, 4'h6, 4'h7, 4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF
    };

    typedef enum int {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_SPARSE,
        RDY_LONG_STALL
    } ready_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned burst_left = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    bundle_branch_predecoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bundle_branch_predecoder_monitor monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic slot_word_t make_slot(input logic [3:0] opcode, input logic [5:0] x6,
                                             input logic [2:0] btype, input logic sign,
                                             input logic [19:0] imm);
        slot_word_t word;
        word        = slot_word_t'({$urandom, $urandom});
        word[40:37] = opcode;
        word[36]    = sign;
        word[32:13] = imm;
        word[8:6]   = btype;
        if (opcode == OP_INDIRECT) begin
            word[32:27] = x6;
        end
        return word;
    endfunction

    function automatic slot_word_t rel_slot(input logic [3:0] opcode);
        return make_slot(opcode, X6_NOP, 3'($urandom), 1'($urandom), 20'($urandom));
    endfunction

    function automatic slot_word_t ind_slot(input logic [5:0] x6, input logic [2:0] btype);
        return make_slot(OP_INDIRECT, x6, btype, 1'($urandom), 20'($urandom));
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_bundle(input tmpl_t tmpl, input slot_word_t s0,
                                                         input slot_word_t s1,
                                                         input slot_word_t s2);
        return {s2, s1, s0, tmpl};
    endfunction

    function automatic slot_word_t random_slot();
        logic [3:0] opcode;
        logic [5:0] x6;
        logic [2:0] btype;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            opcode = OP_CALL_REL;
        end else if (pick < 40) begin
            opcode = OP_BR_REL;
        end else if (pick < 52) begin
            opcode = OP_CALL_IND;
        end else if (pick < 80) begin
            opcode = OP_INDIRECT;
        end else begin
            opcode = 4'($urandom);
        end
        pick = $urandom_range(0, 9);
        x6 = (pick < 4) ? X6_RETURN : (pick < 8) ? X6_BR_IND : 6'($urandom);
        pick = $urandom_range(0, 9);
        btype = (pick < 3) ? BTYPE_RET : (pick < 5) ? BTYPE_COND :
                (pick < 7) ? BTYPE_IA : 3'($urandom);
        return make_slot(opcode, x6, btype, 1'($urandom), 20'($urandom));
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_bundle(input logic [S_TDATA_W-1:0] bundle);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tdata  = bundle;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        burst_left = 0;
    endtask

    initial begin : ready_pattern
        ready_mode_t mode;
        int unsigned seg_len;
        repeat (RESET_CYCLES) @(negedge aclk);
        forever begin
            mode    = ready_mode_t'($urandom_range(0, 3));
            seg_len = $urandom_range(16, 160);
            for (int k = 0; k < seg_len; k++) begin
                @(negedge aclk);
                case (mode)
                    RDY_ALWAYS: begin
                        m_tready = 1'b1;
                    end
                    RDY_RANDOM: begin
                        m_tready = ($urandom_range(0, 3) != 0);
                    end
                    RDY_SPARSE: begin
                        m_tready = (k % 5 == 0);
                    end
                    default: begin
                        m_tready = (k % 40 >= 30);
                    end
                endcase
            end
        end
    end

    initial begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        tmpl_t tmpl;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // field extremes
        send_bundle('0);
        send_bundle('1);
        send_bundle(pack_bundle(TMPL_BBB,
                                make_slot(OP_CALL_REL, X6_NOP, BTYPE_COND, 1'b0, '1),
                                make_slot(OP_BR_REL, X6_NOP, BTYPE_COND, 1'b1, '0),
                                rel_slot(OP_CALL_IND)));
        send_bundle(pack_bundle(TMPL_BBB,
                                {OP_CALL_REL, 37'h1F_FFFF_FFFF},
                                make_slot(OP_BR_REL, X6_NOP, BTYPE_RET, 1'b0, '0),
                                make_slot(OP_BR_REL, X6_NOP, BTYPE_IA, 1'b1, 20'h80000)));
        // return and indirect branch, then near misses that stay other
        send_bundle(pack_bundle(TMPL_BBB_S, ind_slot(X6_RETURN, BTYPE_RET),
                                ind_slot(X6_BR_IND, BTYPE_COND), ind_slot(X6_BR_IND, BTYPE_IA)));
        send_bundle(pack_bundle(TMPL_BBB, ind_slot(X6_RETURN, BTYPE_COND),
                                ind_slot(X6_BR_IND, BTYPE_RET), ind_slot(X6_NOP, BTYPE_RET)));
        for (int k = 0; k < 4; k++) begin
            send_bundle(pack_bundle(TMPL_BBB, rel_slot(SPARE_OPS[3*k]),
                                    rel_slot(SPARE_OPS[3*k+1]), rel_slot(SPARE_OPS[3*k+2])));
        end
        // partial branch-unit templates: slot 0 never decoded
        send_bundle(pack_bundle(TMPL_MBB, rel_slot(OP_CALL_REL), rel_slot(OP_CALL_REL),
                                rel_slot(OP_BR_REL)));
        send_bundle(pack_bundle(TMPL_MBB_S, ind_slot(X6_RETURN, BTYPE_RET),
                                ind_slot(X6_RETURN, BTYPE_RET), ind_slot(X6_BR_IND, BTYPE_COND)));
        send_bundle(pack_bundle(TMPL_MIB, rel_slot(OP_CALL_REL), rel_slot(OP_BR_REL),
                                rel_slot(OP_CALL_REL)));
        send_bundle(pack_bundle(TMPL_MIB_S, rel_slot(OP_CALL_REL), rel_slot(OP_BR_REL),
                                rel_slot(OP_BR_REL)));
        send_bundle(pack_bundle(TMPL_MMB, rel_slot(OP_CALL_REL), rel_slot(OP_CALL_REL),
                                rel_slot(OP_CALL_IND)));
        send_bundle(pack_bundle(TMPL_MMB_S, ind_slot(X6_RETURN, BTYPE_RET),
                                ind_slot(X6_RETURN, BTYPE_RET), ind_slot(X6_RETURN, BTYPE_RET)));
        send_bundle(pack_bundle(TMPL_MFB, rel_slot(OP_BR_REL), rel_slot(OP_CALL_REL),
                                ind_slot(X6_BR_IND, BTYPE_COND)));
        send_bundle(pack_bundle(TMPL_MFB_S, rel_slot(OP_BR_REL), rel_slot(OP_CALL_REL),
                                ind_slot(X6_BR_IND, BTYPE_IA)));
        // long template is not decoded at all
        send_bundle(pack_bundle(TMPL_MLX, rel_slot(OP_CALL_REL), rel_slot(OP_BR_REL),
                                rel_slot(OP_CALL_REL)));
        send_bundle(pack_bundle(TMPL_MLX_S, ind_slot(X6_RETURN, BTYPE_RET),
                                ind_slot(X6_BR_IND, BTYPE_COND), rel_slot(OP_CALL_IND)));
        wait_drained();

        for (int i = 0; i < RANDOM_BUNDLES; i++) begin
            if (i == RANDOM_BUNDLES / 2) begin
                wait_drained();
            end
            if ($urandom_range(0, 99) < 15) begin
                send_bundle({$urandom, $urandom, $urandom, $urandom});
            end else begin
                if ($urandom_range(0, 99) < 80) begin
                    tmpl = BRANCH_TMPLS[$urandom_range(0, 9)];
                end else begin
                    tmpl = tmpl_t'($urandom);
                end
                send_bundle(pack_bundle(tmpl, random_slot(), random_slot(), random_slot()));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bbp_pkg.sv
rtl/bbp_slot_lane.sv
rtl/bbp_merge.sv
rtl/bundle_branch_predecoder.sv
tb/bundle_branch_predecoder_monitor.sv
tb/bundle_branch_predecoder_test.sv
